// ===== sv/i2p_pkg.sv =====
// Shared types, character constants and code tables for the infix-to-postfix converter.
`default_nettype none

package i2p_pkg;

  // Character bytes the converter recognizes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  // Operator stack entry codes
  typedef enum logic [2:0] {
    CODE_LPAREN = 3'd0,
    CODE_PLUS   = 3'd1,
    CODE_MINUS  = 3'd2,
    CODE_MUL    = 3'd3,
    CODE_DIV    = 3'd4,
    CODE_POW    = 3'd5
  } code_e;

  // Item classes handed from the front to the back
  typedef enum logic [2:0] {
    CLS_PASS   = 3'd0,
    CLS_LPAREN = 3'd1,
    CLS_RPAREN = 3'd2,
    CLS_OPER   = 3'd3,
    CLS_END    = 3'd4
  } cls_e;

  typedef struct packed {
    cls_e        cls;
    logic [2:0]  code;
    logic [7:0]  symbol;
  } entry_t;

  // Handshake between the front queue and the back engine
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_req_t;

  function automatic logic [1:0] code_prec(input logic [2:0] code);
    logic [1:0] p;
    p = 2'd0;
    unique case (code)
      CODE_PLUS, CODE_MINUS: p = 2'd1;
      CODE_MUL, CODE_DIV:    p = 2'd2;
      CODE_POW:              p = 2'd3;
      default:               p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] code_char(input logic [2:0] code);
    logic [7:0] c;
    c = 8'h00;
    unique case (code)
      CODE_LPAREN: c = CH_LPAREN;
      CODE_PLUS:   c = CH_PLUS;
      CODE_MINUS:  c = CH_MINUS;
      CODE_MUL:    c = CH_STAR;
      CODE_DIV:    c = CH_SLASH;
      CODE_POW:    c = CH_CARET;
      default:     c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic entry_t classify(input logic op, input logic [7:0] symbol);
    entry_t e;
    e.cls    = CLS_PASS;
    e.code   = CODE_LPAREN;
    e.symbol = symbol;
    if (op) begin
      e.cls = CLS_END;
    end else begin
      unique case (symbol)
        CH_LPAREN: e.cls = CLS_LPAREN;
        CH_RPAREN: e.cls = CLS_RPAREN;
        CH_PLUS:   begin e.cls = CLS_OPER; e.code = CODE_PLUS;  end
        CH_MINUS:  begin e.cls = CLS_OPER; e.code = CODE_MINUS; end
        CH_STAR:   begin e.cls = CLS_OPER; e.code = CODE_MUL;   end
        CH_SLASH:  begin e.cls = CLS_OPER; e.code = CODE_DIV;   end
        CH_CARET:  begin e.cls = CLS_OPER; e.code = CODE_POW;   end
        default:   e.cls = CLS_PASS;
      endcase
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== sv/i2p_front.sv =====
// Front end: classifies incoming beats and holds them in a two-entry queue.
`default_nettype none

module i2p_front import i2p_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       op_i,
  input  wire logic [7:0] symbol_i,
  output q_req_t          q_req_o,
  input  wire logic       q_take_i
);

  entry_t     slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = q_take_i && (cnt_q != 2'd0);

  assign q_req_o.valid = (cnt_q != 2'd0);
  assign q_req_o.entry = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= classify(op_i, symbol_i);
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("front queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("front queue pointers disagree with count");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("front queue lost a beat");

endmodule

`default_nettype wire

// ===== sv/i2p_back.sv =====
// Back end: operator stack engine, result hold stage and output register.
`default_nettype none

module i2p_back import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire q_req_t     q_req_i,
  output logic            q_take_o,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_symbol_o,
  output logic            run_last_o,
  output logic            terminator_o,
  output logic            overflowed_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOOK = 8'b0000_0010,
    S_READ = 8'b0000_0100,
    S_EVAL = 8'b0000_1000,
    S_PUSH = 8'b0001_0000,
    S_TERM = 8'b0010_0000,
    S_PASS = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e      state_q, state_d;
  entry_t      cur_q, cur_d;
  logic [CW-1:0] count_q, count_d;
  logic        ovf_q, ovf_d;

  // Stack memory: one write port, one registered read port at the top
  logic [2:0]  stack_mem [STACK_DEPTH];
  logic [2:0]  rd_q;
  logic        wr_en;
  logic [2:0]  wr_data;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Hold stage: the newest result waits here until we know if it is the last
  logic        hold_v_q, hold_v_d;
  logic [7:0]  hold_sym_q, hold_sym_d;
  logic        hold_term_q, hold_term_d;
  logic        hold_ovf_q, hold_ovf_d;

  logic        out_v_q, out_v_d;
  logic [7:0]  out_sym_q, out_sym_d;
  logic        out_last_q, out_last_d;
  logic        out_term_q, out_term_d;
  logic        out_ovf_q, out_ovf_d;

  logic        out_ready;
  logic        can_emit;
  logic        emit_req;
  logic [7:0]  emit_sym;
  logic        emit_term;
  logic        emit_ovf;
  logic        fin_move;
  logic        push_req;
  logic        stack_full;
  logic        top_goes;

  assign out_ready  = !out_v_q || pop;
  assign can_emit   = !hold_v_q || out_ready;
  assign stack_full = (count_q >= CW'(STACK_DEPTH));
  assign rd_addr    = AW'(count_q - CW'(1));
  assign wr_addr    = AW'(count_q);

  assign empty        = !out_v_q;
  assign out_symbol_o = out_sym_q;
  assign run_last_o   = out_last_q;
  assign terminator_o = out_term_q;
  assign overflowed_o = out_ovf_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    q_take_o  = 1'b0;
    emit_req  = 1'b0;
    emit_sym  = 8'h00;
    emit_term = 1'b0;
    emit_ovf  = 1'b0;
    fin_move  = 1'b0;
    push_req  = 1'b0;
    top_goes  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_req_i.valid) begin
          q_take_o = 1'b1;
          cur_d    = q_req_i.entry;
          state_d  = S_LOOK;
        end
      end
      S_LOOK: begin
        // rd_q picks up the top entry during this cycle
        unique case (cur_q.cls)
          CLS_PASS:   state_d = S_PASS;
          CLS_LPAREN: state_d = S_PUSH;
          CLS_RPAREN: state_d = (count_q == '0) ? S_FIN  : S_EVAL;
          CLS_OPER:   state_d = (count_q == '0) ? S_PUSH : S_EVAL;
          CLS_END:    state_d = (count_q == '0) ? S_TERM : S_EVAL;
          default:    state_d = S_FIN;
        endcase
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        emit_sym = code_char(rd_q);
        priority if (cur_q.cls == CLS_RPAREN && rd_q == CODE_LPAREN) begin
          // drop the matching open paren
          count_d = count_q - CW'(1);
          state_d = S_FIN;
        end else if (cur_q.cls == CLS_OPER &&
                     code_prec(rd_q) < code_prec(cur_q.code)) begin
          state_d = S_PUSH;
        end else begin
          emit_req = 1'b1;
          if (can_emit) begin
            top_goes = 1'b1;
            count_d  = count_q - CW'(1);
            if (count_q == CW'(1)) begin
              unique case (cur_q.cls)
                CLS_OPER: state_d = S_PUSH;
                CLS_END:  state_d = S_TERM;
                default:  state_d = S_FIN;
              endcase
            end else begin
              state_d = S_READ;
            end
          end
        end
      end
      S_PUSH: begin
        push_req = 1'b1;
        if (stack_full) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + CW'(1);
        end
        state_d = S_FIN;
      end
      S_TERM: begin
        emit_req  = 1'b1;
        emit_term = 1'b1;
        emit_ovf  = ovf_q;
        if (can_emit) begin
          ovf_d   = 1'b0;
          state_d = S_FIN;
        end
      end
      S_PASS: begin
        emit_req = 1'b1;
        emit_sym = cur_q.symbol;
        if (can_emit) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!hold_v_q) begin
          state_d = S_IDLE;
        end else if (out_ready) begin
          fin_move = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign wr_en   = push_req && !stack_full;
  assign wr_data = cur_q.code;

  // Hold stage and output register
  always_comb begin
    hold_v_d    = hold_v_q;
    hold_sym_d  = hold_sym_q;
    hold_term_d = hold_term_q;
    hold_ovf_d  = hold_ovf_q;
    out_v_d     = out_v_q && !pop;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    out_term_d  = out_term_q;
    out_ovf_d   = out_ovf_q;

    if (emit_req && can_emit) begin
      if (hold_v_q) begin
        out_v_d    = 1'b1;
        out_sym_d  = hold_sym_q;
        out_last_d = 1'b0;
        out_term_d = hold_term_q;
        out_ovf_d  = hold_ovf_q;
      end
      hold_v_d    = 1'b1;
      hold_sym_d  = emit_sym;
      hold_term_d = emit_term;
      hold_ovf_d  = emit_ovf;
    end else if (fin_move) begin
      out_v_d    = 1'b1;
      out_sym_d  = hold_sym_q;
      out_last_d = 1'b1;
      out_term_d = hold_term_q;
      out_ovf_d  = hold_ovf_q;
      hold_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    hold_sym_q  <= hold_sym_d;
    hold_term_q <= hold_term_d;
    hold_ovf_q  <= hold_ovf_d;
    out_sym_q   <= out_sym_d;
    out_last_q  <= out_last_d;
    out_term_q  <= out_term_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_q <= stack_mem[rd_addr];
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !hold_v_q)
    else $error("result left in hold stage between items");

  a_term_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TERM) |-> (count_q == '0))
    else $error("terminator issued with operators still stacked");

  a_term_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_term_q) |-> out_last_q)
    else $error("terminator not marked as last of its run");

  a_pop_needs_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_goes |-> (count_q != '0))
    else $error("pop from an empty stack");

endmodule

`default_nettype wire

// ===== sv/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix-to-postfix converter.
`default_nettype none

// Takes an infix expression one byte per beat and returns its postfix form as
// a stream of result beats. Operators + - * / ^ (precedence 1 1 2 2 3, all
// left-associative) and '(' wait on an operator stack of STACK_DEPTH entries;
// any other byte passes through. An end beat (op_i high) flushes the stack,
// top first, then returns a terminator beat whose overflowed_o is set if any
// push since the previous end beat found the stack full (that push is
// dropped). run_last_o marks the last result of each input beat; beats that
// produce nothing ('(' itself, an operator that pops nothing, ')' on an empty
// stack) return no result. Flow: a two-entry queue takes input beats while
// the engine works. A pass-through byte or a push onto an empty stack goes
// through dequeue, decode, act and release. When the stack is not empty, an
// operator, ')' or end beat looks at the top entry first: each entry popped
// takes a compare, then a re-read of the top through the single registered
// read port of the stack memory; the pop that empties the stack saves the
// re-read, and an operator that stops on a lower entry compares it before
// its push. A result waits in a hold stage until the engine knows whether
// it is the last of its run, then moves to the output register; the engine
// stalls whenever both are occupied and pop is low.
module infix_to_postfix_converter import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input queue side
  input  wire logic       push,
  output logic            full,
  input  wire logic       op_i,
  input  wire logic [7:0] symbol_i,
  // result queue side
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_symbol_o,
  output logic            run_last_o,
  output logic            terminator_o,
  output logic            overflowed_o
);

  q_req_t q_req;
  logic   q_take;

  // Classify each beat and queue it for the engine
  i2p_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .op_i     (op_i),
    .symbol_i (symbol_i),
    .q_req_o  (q_req),
    .q_take_i (q_take)
  );

  // Run the stack algorithm and drive the result queue
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_req_i      (q_req),
    .q_take_o     (q_take),
    .empty        (empty),
    .pop          (pop),
    .out_symbol_o (out_symbol_o),
    .run_last_o   (run_last_o),
    .terminator_o (terminator_o),
    .overflowed_o (overflowed_o)
  );

endmodule

`default_nettype wire

// ===== tb/infix_to_postfix_checker.sv =====
// Checker for the infix-to-postfix converter: predicts the postfix beats and compares them.
`default_nettype none

module infix_to_postfix_checker import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic       op_i,
  input  wire logic [7:0] symbol_i,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic [7:0] out_symbol_o,
  input  wire logic       run_last_o,
  input  wire logic       terminator_o,
  input  wire logic       overflowed_o,
  output int              mismatches,
  output int              postfix_left
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       term;
    logic       ovf;
  } postfix_beat_t;

  postfix_beat_t postfix_due[$];
  code_e         op_stack[STACK_DEPTH];
  int            depth;
  bit            ovf_pending;

  initial begin
    mismatches   = 0;
    postfix_left = 0;
  end

  function automatic int rank(input code_e c);
    case (c)
      CODE_PLUS, CODE_MINUS: return 1;
      CODE_MUL, CODE_DIV:    return 2;
      CODE_POW:              return 3;
      default:               return 0;
    endcase
  endfunction

  function automatic logic [7:0] glyph(input code_e c);
    case (c)
      CODE_PLUS:  return CH_PLUS;
      CODE_MINUS: return CH_MINUS;
      CODE_MUL:   return CH_STAR;
      CODE_DIV:   return CH_SLASH;
      CODE_POW:   return CH_CARET;
      default:    return CH_LPAREN;
    endcase
  endfunction

  task automatic queue_beat(input logic [7:0] s, input logic t, input logic o);
    postfix_beat_t b;
    b.sym  = s;
    b.last = 1'b0;
    b.term = t;
    b.ovf  = o;
    postfix_due.push_back(b);
  endtask

  task automatic pop_op();
    depth--;
    queue_beat(glyph(op_stack[depth]), 1'b0, 1'b0);
  endtask

  task automatic push_op(input code_e c);
    if (depth >= STACK_DEPTH) begin
      ovf_pending = 1'b1;
    end else begin
      op_stack[depth] = c;
      depth++;
    end
  endtask

  // Work out every postfix beat that one accepted input beat causes.
  task automatic predict_postfix(input logic end_flag, input logic [7:0] ch);
    int            due_start;
    bit            is_op;
    code_e         c;
    postfix_beat_t tail;
    due_start = postfix_due.size();
    is_op  = 1'b1;
    c      = CODE_PLUS;
    if (end_flag) begin
      while (depth > 0) pop_op();
      queue_beat(8'h00, 1'b1, ovf_pending);
      ovf_pending = 1'b0;
    end else begin
      case (ch)
        CH_PLUS:  c = CODE_PLUS;
        CH_MINUS: c = CODE_MINUS;
        CH_STAR:  c = CODE_MUL;
        CH_SLASH: c = CODE_DIV;
        CH_CARET: c = CODE_POW;
        default:  is_op = 1'b0;
      endcase
      if (ch == CH_LPAREN) begin
        push_op(CODE_LPAREN);
      end else if (ch == CH_RPAREN) begin
        while (depth > 0 && op_stack[depth-1] != CODE_LPAREN) pop_op();
        if (depth > 0) depth--;
      end else if (is_op) begin
        while (depth > 0 && rank(op_stack[depth-1]) >= rank(c)) pop_op();
        push_op(c);
      end else begin
        queue_beat(ch, 1'b0, 1'b0);
      end
    end
    if (postfix_due.size() > due_start) begin
      tail      = postfix_due.pop_back();
      tail.last = 1'b1;
      postfix_due.push_back(tail);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    postfix_beat_t want;
    if (!rst_ni) begin
      depth       = 0;
      ovf_pending = 1'b0;
      postfix_due.delete();
    end else begin
      if (push && !full) predict_postfix(op_i, symbol_i);
      if (pop && !empty) begin
        if (postfix_due.size() == 0) begin
          report_mismatch($sformatf("result beat %02h with nothing due", out_symbol_o));
        end else begin
          want = postfix_due.pop_front();
          if (out_symbol_o !== want.sym)
            report_mismatch($sformatf("out_symbol got %02h want %02h", out_symbol_o, want.sym));
          if (run_last_o !== want.last)
            report_mismatch($sformatf("run_last got %b want %b", run_last_o, want.last));
          if (terminator_o !== want.term)
            report_mismatch($sformatf("terminator got %b want %b", terminator_o, want.term));
          if (overflowed_o !== want.ovf)
            report_mismatch($sformatf("overflowed got %b want %b", overflowed_o, want.ovf));
        end
      end
    end
    postfix_left <= postfix_due.size();
  end

endmodule

`default_nettype wire

// ===== tb/infix_to_postfix_converter_tb.sv =====
// Testbench top for the infix-to-postfix converter: stimulus, idling phases and verdict.
`default_nettype none

module infix_to_postfix_converter_tb import i2p_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 16;
  localparam int DRAIN_WAIT  = 40;

  localparam logic [7:0] OPER_CHARS[5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
  localparam logic [7:0] SPECIAL_CHARS[7] =
    '{CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       op_i = 1'b0;
  logic [7:0] symbol_i = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_symbol_o;
  logic       run_last_o;
  logic       terminator_o;
  logic       overflowed_o;

  int mismatches;
  int postfix_left;
  int beats_sent = 0;
  int cycles = 0;
  int idle_pct = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;  // chance per cycle that the receiver holds pop low

  always #5 clk_i = ~clk_i;

  infix_to_postfix_converter #(.STACK_DEPTH(DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .symbol_i     (symbol_i),
    .empty        (empty),
    .pop          (pop),
    .out_symbol_o (out_symbol_o),
    .run_last_o   (run_last_o),
    .terminator_o (terminator_o),
    .overflowed_o (overflowed_o)
  );

  // The checker watches both queues, runs its own operator stack and
  // compares every popped beat against the oldest prediction.
  infix_to_postfix_checker #(.STACK_DEPTH(DEPTH)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .symbol_i     (symbol_i),
    .empty        (empty),
    .pop          (pop),
    .out_symbol_o (out_symbol_o),
    .run_last_o   (run_last_o),
    .terminator_o (terminator_o),
    .overflowed_o (overflowed_o),
    .mismatches   (mismatches),
    .postfix_left (postfix_left)
  );

  // Drop pop at random while the receiver stalls; hold it high otherwise.
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one input beat and hold it until the converter takes it. Idle
  // cycles go in front of the beat, so a gap can land on any engine state.
  task automatic send_beat(input logic end_flag, input logic [7:0] ch);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    op_i     <= end_flag;
    symbol_i <= ch;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_sent++;
  endtask

  // Any byte that is not an operator or a parenthesis is an operand.
  task automatic send_operand();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b inside {SPECIAL_CHARS}) b = 8'($urandom_range(0, 255));
    send_beat(1'b0, b);
  endtask

  // Well-formed expression: operands joined by random operators, with
  // balanced parentheses up to four deep, closed by an end beat.
  task automatic send_expression();
    int terms;
    int opens;
    terms = $urandom_range(1, 6);
    opens = 0;
    for (int i = 0; i < terms; i++) begin
      if (i > 0) send_beat(1'b0, OPER_CHARS[$urandom_range(0, 4)]);
      if (opens < 4 && $urandom_range(0, 3) == 0) begin
        send_beat(1'b0, CH_LPAREN);
        opens++;
      end
      send_operand();
      if (opens > 0 && $urandom_range(0, 2) == 0) begin
        send_beat(1'b0, CH_RPAREN);
        opens--;
      end
    end
    while (opens > 0) begin
      send_beat(1'b0, CH_RPAREN);
      opens--;
    end
    send_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Broken sequences: stray specials, raw bytes and early end beats.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0)
        send_beat($urandom_range(0, 9) == 0, SPECIAL_CHARS[$urandom_range(0, 6)]);
      else
        send_beat($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int idle, input int stall);
    int goal;
    idle_pct  = idle;
    stall_pct = stall;
    goal      = beats_sent + PHASE_BEATS;
    while (beats_sent < goal) begin
      if ($urandom_range(0, 99) < 80) send_expression();
      else send_noise();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme bytes through parentheses, every operator,
    // caret chaining left to right, unmatched and lone close parens.
    send_beat(1'b0, CH_LPAREN);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, CH_PLUS);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, CH_RPAREN);
    send_beat(1'b0, CH_MINUS);
    send_beat(1'b0, "x");
    send_beat(1'b0, CH_STAR);
    send_beat(1'b0, "y");
    send_beat(1'b0, CH_SLASH);   // pops the '*' of equal rank
    send_beat(1'b0, "z");
    send_beat(1'b0, CH_CARET);
    send_beat(1'b0, "w");
    send_beat(1'b0, CH_CARET);   // left-associative: pops the earlier '^'
    send_beat(1'b0, "v");
    send_beat(1'b0, CH_RPAREN);  // no '(' waiting: empties the whole stack
    send_beat(1'b0, CH_RPAREN);  // empty stack: no result at all
    send_beat(1'b1, 8'hFF);      // end on an empty stack, symbol ignored
    send_beat(1'b1, 8'h00);
    send_beat(1'b0, CH_LPAREN);
    send_beat(1'b0, CH_LPAREN);
    send_beat(1'b1, 8'h00);      // flush leaves the '(' bytes in the output

    // Overflow: fill the stack exactly, then push one more '(' and an
    // operator that pops nothing; both pushes drop and set the flag.
    repeat (DEPTH + 1) send_beat(1'b0, CH_LPAREN);
    send_beat(1'b0, CH_PLUS);
    send_beat(1'b0, "q");
    send_beat(1'b1, 8'h5A);
    // Full stack flushed by one end beat: the most results one beat gives.
    repeat (DEPTH) send_beat(1'b0, CH_LPAREN);
    send_beat(1'b1, 8'hA5);

    // Random part across the idling phases.
    run_phase(0, 0);
    run_phase(87, 0);
    run_phase(0, 87);
    run_phase(8, 8);

    // Drain: stop stalling and wait out every expected beat.
    push      <= 1'b0;
    stall_pct = 0;
    do @(posedge clk_i); while (postfix_left != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && postfix_left == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
